// ----- hdl/kzma_pkg.sv -----
`timescale 1ns / 1ps

package kzma_pkg;

	localparam int MAX_HALF = 7;
	localparam int MAX_ITERS = 8;
	localparam int SAMPLE_BITS = 32;

	localparam int PORT_BITS = 32;
	localparam int HALF_BITS = 3;
	localparam int ITERS_BITS = 4;
	localparam int CFG_DATA_BITS = 4;
	localparam int CFG_INDEX_BITS = 1;

	// Quotient bits resolved per cycle by the divider in each cell.
	localparam int DIGIT_BITS = 4;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_HALF_WIDTH = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] CFG_ITERATIONS = CFG_INDEX_BITS'(1);

	localparam logic [HALF_BITS-1:0] HALF_RESET = HALF_BITS'(1);
	localparam logic [ITERS_BITS-1:0] ITERS_RESET = ITERS_BITS'(3);

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_DIV
	} cell_state_t;

	typedef struct packed {
		logic clear;
		logic active;
		logic [HALF_BITS-1:0] half;
	} cell_ctrl_t;

endpackage

// ----- hdl/kzma_if.sv -----
`timescale 1ns / 1ps

interface kzma_in_if;
	logic valid;
	logic ready;
	logic [kzma_pkg::PORT_BITS-1:0] sample;
	logic last_in;

	modport source (output valid, output sample, output last_in, input ready);
	modport sink (input valid, input sample, input last_in, output ready);
endinterface

interface kzma_out_if;
	logic valid;
	logic ready;
	logic [kzma_pkg::PORT_BITS-1:0] smoothed;
	logic last_out;

	modport source (output valid, output smoothed, output last_out, input ready);
	modport sink (input valid, input smoothed, input last_out, output ready);
endinterface

// ----- hdl/kzma_cell.sv -----
`timescale 1ns / 1ps

module kzma_cell #(
	parameter int MAX_HALF = kzma_pkg::MAX_HALF,
	parameter int SAMPLE_BITS = kzma_pkg::SAMPLE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  kzma_pkg::cell_ctrl_t ctrl,
	input  logic in_valid,
	output logic in_ready,
	input  logic [SAMPLE_BITS-1:0] in_sample,
	input  logic in_last,
	output logic out_valid,
	input  logic out_ready,
	output logic [SAMPLE_BITS-1:0] out_sample,
	output logic out_last
);

	localparam int WIN_DEPTH = 2 * MAX_HALF + 1;
	localparam int CNT_W = $clog2(WIN_DEPTH + 1);
	localparam int IDX_W = $clog2(WIN_DEPTH);
	localparam int SUM_W = SAMPLE_BITS + $clog2(WIN_DEPTH);
	localparam int DIV_STEPS = (SUM_W + kzma_pkg::DIGIT_BITS - 1) / kzma_pkg::DIGIT_BITS;
	localparam int DIV_W = DIV_STEPS * kzma_pkg::DIGIT_BITS;
	localparam int STEP_W = $clog2(DIV_STEPS + 1);

	kzma_pkg::cell_state_t state_q, state_d;

	logic [SAMPLE_BITS-1:0] win_q [WIN_DEPTH];
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] fill_q;
	logic [CNT_W-1:0] emitted_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] pend_q;
	logic flush_q;
	logic [SUM_W-1:0] acc_q;
	logic [DIV_W-1:0] dq_q;
	logic [CNT_W-1:0] rem_q;
	logic [STEP_W-1:0] step_q;
	logic out_valid_q;
	logic [SAMPLE_BITS-1:0] out_sample_q;
	logic out_last_q;

	logic [CNT_W-1:0] h_cnt;
	logic [CNT_W-1:0] len;
	logic [IDX_W-1:0] rd_idx;
	logic [SAMPLE_BITS-1:0] rd_data;
	logic out_free;
	logic accept;
	logic out_set;
	logic full;
	logic [CNT_W-1:0] fill_n;
	logic [CNT_W-1:0] emit_n;
	logic [SUM_W-1:0] sum_n;
	logic [CNT_W-1:0] pend_n;
	logic want;
	logic div_done;
	logic load;
	logic more;
	logic [CNT_W-1:0] pend_nx;
	logic drop;
	logic [SUM_W-1:0] acc_nx;
	logic [CNT_W-1:0] rem_x;
	logic [DIV_W-1:0] dq_x;
	logic [CNT_W:0] trial;

	assign h_cnt = CNT_W'(ctrl.half);
	assign len = CNT_W'({ctrl.half, 1'b1});

	// One read port serves both the eviction on a push and the window shrink during a flush.
	assign rd_idx = (state_q == kzma_pkg::ST_IDLE) ? IDX_W'(len - 1'b1) : IDX_W'(cnt_q - 1'b1);
	assign rd_data = win_q[rd_idx];

	assign out_free = !out_valid_q || out_ready;
	assign accept = in_valid && in_ready;

	assign full = fill_q >= len;
	assign fill_n = full ? fill_q : fill_q + 1'b1;
	assign emit_n = (full && emitted_q != '0) ? emitted_q - 1'b1 : emitted_q;
	assign sum_n = sum_q - (full ? SUM_W'(rd_data) : '0) + SUM_W'(in_sample);
	assign pend_n = fill_n - emit_n;
	assign want = in_last || (pend_n > h_cnt);

	assign div_done = step_q == STEP_W'(DIV_STEPS);
	assign load = (state_q == kzma_pkg::ST_DIV) && div_done && out_free;
	assign more = flush_q && (pend_q != CNT_W'(1));
	assign pend_nx = pend_q - 1'b1;
	assign drop = (pend_nx + h_cnt) < cnt_q;
	assign acc_nx = drop ? acc_q - SUM_W'(rd_data) : acc_q;

	assign out_set = !ctrl.clear && ((accept && !ctrl.active) || load);

	always_comb begin
		rem_x = rem_q;
		dq_x = dq_q;
		trial = '0;
		for (int i = 0; i < kzma_pkg::DIGIT_BITS; i++) begin
			trial = {rem_x, dq_x[DIV_W-1]};
			dq_x = {dq_x[DIV_W-2:0], 1'b0};
			if (trial >= {1'b0, cnt_q}) begin
				trial = trial - {1'b0, cnt_q};
				dq_x[0] = 1'b1;
			end
			rem_x = trial[CNT_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= kzma_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		unique case (state_q)
			kzma_pkg::ST_IDLE: begin
				in_ready = out_free;
				if (accept && ctrl.active && want) begin
					state_d = kzma_pkg::ST_DIV;
				end
			end
			kzma_pkg::ST_DIV: begin
				if (load && !more) begin
					state_d = kzma_pkg::ST_IDLE;
				end
			end
			default: state_d = kzma_pkg::ST_IDLE;
		endcase
		if (ctrl.clear) begin
			state_d = kzma_pkg::ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sum_q <= '0;
			fill_q <= '0;
			emitted_q <= '0;
			cnt_q <= '0;
			pend_q <= '0;
			flush_q <= 1'b0;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_set) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (ctrl.clear) begin
				sum_q <= '0;
				fill_q <= '0;
				emitted_q <= '0;
				step_q <= '0;
			end else if (accept && ctrl.active) begin
				fill_q <= fill_n;
				emitted_q <= emit_n;
				sum_q <= sum_n;
				if (want) begin
					pend_q <= pend_n;
					cnt_q <= fill_n;
					flush_q <= in_last;
					step_q <= '0;
				end
			end else if (state_q == kzma_pkg::ST_DIV) begin
				if (!div_done) begin
					step_q <= step_q + 1'b1;
				end else if (out_free) begin
					if (more) begin
						pend_q <= pend_nx;
						emitted_q <= emitted_q + 1'b1;
						step_q <= '0;
						if (drop) begin
							cnt_q <= cnt_q - 1'b1;
						end
					end else if (flush_q) begin
						sum_q <= '0;
						fill_q <= '0;
						emitted_q <= '0;
					end else begin
						emitted_q <= emitted_q + 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && ctrl.active) begin
			win_q[0] <= in_sample;
			for (int k = 1; k < WIN_DEPTH; k++) begin
				win_q[k] <= win_q[k-1];
			end
			if (want) begin
				acc_q <= sum_n;
				dq_q <= DIV_W'(sum_n);
				rem_q <= '0;
			end
		end
		if (state_q == kzma_pkg::ST_DIV) begin
			if (!div_done) begin
				dq_q <= dq_x;
				rem_q <= rem_x;
			end else if (out_free && more) begin
				acc_q <= acc_nx;
				dq_q <= DIV_W'(acc_nx);
				rem_q <= '0;
			end
		end
		if (accept && !ctrl.active) begin
			out_sample_q <= in_sample;
			out_last_q <= in_last;
		end else if (load) begin
			out_sample_q <= dq_q[SAMPLE_BITS-1:0];
			out_last_q <= flush_q && (pend_q == CNT_W'(1));
		end
	end

	assign out_valid = out_valid_q;
	assign out_sample = out_sample_q;
	assign out_last = out_last_q;

endmodule

// ----- hdl/kzma_iterated_moving_average.sv -----
// Iterated centered moving average over a stream of unsigned Q24.8 samples, built as a
// row of identical cells, one per pass, each holding its own window of up to 2h+1
// samples and a running sum. The configured number of cells average; the rest, and all
// of them when half_width is zero, forward each transfer through an output register. An
// averaging cell takes a new sample only while it is idle and takes none while its
// divider works on a result; the divider resolves four quotient bits per cycle. The
// sample marked last drains every averaging cell, with up to h+1 results per cell, each
// through the divider, and leaves the cells ready for a new sequence.
// A write to either configuration register discards any sequence in progress.
`timescale 1ns / 1ps

module kz_iterated_moving_average #(
	parameter int MAX_HALF = kzma_pkg::MAX_HALF,
	parameter int MAX_ITERS = kzma_pkg::MAX_ITERS,
	parameter int SAMPLE_BITS = kzma_pkg::SAMPLE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	kzma_in_if.sink sample_chan,
	kzma_out_if.source result_chan,
	input  logic cfg_we,
	input  logic [kzma_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [kzma_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	logic [kzma_pkg::HALF_BITS-1:0] half_q;
	logic [kzma_pkg::ITERS_BITS-1:0] iters_q;
	logic [kzma_pkg::HALF_BITS-1:0] h_eff;
	logic [kzma_pkg::ITERS_BITS-1:0] iters_eff;
	logic [MAX_ITERS-1:0] active;

	logic ch_valid [MAX_ITERS+1];
	logic ch_ready [MAX_ITERS+1];
	logic [SAMPLE_BITS-1:0] ch_sample [MAX_ITERS+1];
	logic ch_last [MAX_ITERS+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_q <= kzma_pkg::HALF_RESET;
			iters_q <= kzma_pkg::ITERS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				kzma_pkg::CFG_HALF_WIDTH: half_q <= cfg_data[kzma_pkg::HALF_BITS-1:0];
				kzma_pkg::CFG_ITERATIONS: iters_q <= cfg_data[kzma_pkg::ITERS_BITS-1:0];
				default: ;
			endcase
		end
	end

	assign h_eff = (half_q > kzma_pkg::HALF_BITS'(MAX_HALF)) ?
		kzma_pkg::HALF_BITS'(MAX_HALF) : half_q;
	assign iters_eff = (iters_q > kzma_pkg::ITERS_BITS'(MAX_ITERS)) ?
		kzma_pkg::ITERS_BITS'(MAX_ITERS) : iters_q;

	assign ch_valid[0] = sample_chan.valid;
	assign sample_chan.ready = ch_ready[0];
	assign ch_sample[0] = SAMPLE_BITS'(sample_chan.sample);
	assign ch_last[0] = sample_chan.last_in;

	for (genvar g = 0; g < MAX_ITERS; g++) begin : g_cell
		kzma_pkg::cell_ctrl_t ctrl;

		assign active[g] = (h_eff != '0) && (iters_eff > kzma_pkg::ITERS_BITS'(g));
		assign ctrl = '{clear: cfg_we, active: active[g], half: h_eff};

		kzma_cell #(
			.MAX_HALF(MAX_HALF),
			.SAMPLE_BITS(SAMPLE_BITS)
		) u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctrl(ctrl),
			.in_valid(ch_valid[g]),
			.in_ready(ch_ready[g]),
			.in_sample(ch_sample[g]),
			.in_last(ch_last[g]),
			.out_valid(ch_valid[g+1]),
			.out_ready(ch_ready[g+1]),
			.out_sample(ch_sample[g+1]),
			.out_last(ch_last[g+1])
		);
	end

	assign result_chan.valid = ch_valid[MAX_ITERS];
	assign ch_ready[MAX_ITERS] = result_chan.ready;
	assign result_chan.smoothed = kzma_pkg::PORT_BITS'(ch_sample[MAX_ITERS]);
	assign result_chan.last_out = ch_last[MAX_ITERS];

	a_iters_active : assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == kzma_pkg::CFG_ITERATIONS && h_eff != '0 &&
		cfg_data <= kzma_pkg::CFG_DATA_BITS'(MAX_ITERS))
		|=> ($countones(active) == int'($past(cfg_data))))
		else $error("active cell count does not follow the iterations write");

	a_half_zero_bypass : assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && cfg_index == kzma_pkg::CFG_HALF_WIDTH &&
		cfg_data[kzma_pkg::HALF_BITS-1:0] == '0)
		|=> (active == '0))
		else $error("a cell still averages after half width was set to zero");

	a_active_prefix : assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> ((active & (active + 1'b1)) == '0))
		else $error("averaging cells do not form a prefix of the chain");

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

	localparam int DRAIN_CYCLES = 200;
	localparam int WIN_SLOTS = 2 * kzma_pkg::MAX_HALF + 1;
	localparam int RANDOM_BUDGET = 42;

	typedef struct packed {
		logic [kzma_pkg::PORT_BITS-1:0] smoothed;
		logic last_out;
	} smooth_t;

	class kz_smoother;
		logic [kzma_pkg::HALF_BITS-1:0] half;
		logic [kzma_pkg::ITERS_BITS-1:0] iters;
		logic [kzma_pkg::PORT_BITS-1:0] win [kzma_pkg::MAX_ITERS][WIN_SLOTS];
		int unsigned held [kzma_pkg::MAX_ITERS];
		int unsigned done [kzma_pkg::MAX_ITERS];
		smooth_t emerged[$];
		smooth_t awaited[$];
		int unsigned mismatches;

		function new();
			half = kzma_pkg::HALF_RESET;
			iters = kzma_pkg::ITERS_RESET;
			mismatches = 0;
			clear_all();
		endfunction

		function void clear_stage(int unsigned s);
			for (int k = 0; k < WIN_SLOTS; k++) win[s][k] = '0;
			held[s] = 0;
			done[s] = 0;
		endfunction

		function void clear_all();
			for (int s = 0; s < kzma_pkg::MAX_ITERS; s++) clear_stage(s);
		endfunction

		function void write_reg(logic [kzma_pkg::CFG_INDEX_BITS-1:0] index,
				logic [kzma_pkg::CFG_DATA_BITS-1:0] data);
			if (index == kzma_pkg::CFG_HALF_WIDTH) begin
				half = data[kzma_pkg::HALF_BITS-1:0];
			end else begin
				iters = data[kzma_pkg::ITERS_BITS-1:0];
			end
			clear_all();
		endfunction

		// One cascade cell: the window holds the newest sample at slot 0.
		function void average_into(int unsigned s, int unsigned h,
				logic [kzma_pkg::PORT_BITS-1:0] x, logic last);
			int unsigned len;
			int unsigned pend;
			int unsigned cnt;
			int unsigned k;
			logic [35:0] acc;
			smooth_t r;
			len = 2 * h + 1;
			if (held[s] >= len) begin
				if (done[s] > 0) done[s]--;
			end else begin
				held[s]++;
			end
			for (k = held[s] - 1; k > 0; k--) win[s][k] = win[s][k-1];
			win[s][0] = x;
			forever begin
				pend = held[s] - done[s];
				if (!(pend > h || (last && pend > 0))) break;
				cnt = pend + h;
				if (cnt > held[s]) cnt = held[s];
				acc = '0;
				for (k = 0; k < cnt; k++) acc += win[s][k];
				r.smoothed = kzma_pkg::PORT_BITS'(acc / 36'(cnt));
				r.last_out = last && (pend == 1);
				emerged = {emerged, r};
				done[s]++;
			end
			if (last) clear_stage(s);
		endfunction

		function void take_sample(logic [kzma_pkg::PORT_BITS-1:0] x, logic last);
			smooth_t feed[$];
			smooth_t one;
			int unsigned h;
			int unsigned n;
			int unsigned s;
			h = (half > kzma_pkg::MAX_HALF) ? kzma_pkg::MAX_HALF : half;
			n = (iters > kzma_pkg::MAX_ITERS) ? kzma_pkg::MAX_ITERS : iters;
			one.smoothed = x;
			one.last_out = last;
			feed = {one};
			if (h != 0) begin
				for (s = 0; s < n; s++) begin
					emerged.delete();
					foreach (feed[i]) average_into(s, h, feed[i].smoothed, feed[i].last_out);
					feed = emerged;
				end
			end
			awaited = {awaited, feed};
		endfunction

		function void check_smoothed(logic [kzma_pkg::PORT_BITS-1:0] val, logic last);
			smooth_t e;
			if (awaited.size() == 0) begin
				if (mismatches < 10)
					$display("unexpected result: smoothed=%h last_out=%b", val, last);
				mismatches++;
				return;
			end
			e = awaited.pop_front();
			if (e.smoothed !== val || e.last_out !== last) begin
				if (mismatches < 10)
					$display({"result mismatch: expected smoothed=%h last_out=%b, ",
						"got smoothed=%h last_out=%b"},
						e.smoothed, e.last_out, val, last);
				mismatches++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [kzma_pkg::CFG_INDEX_BITS-1:0] cfg_index;
	logic [kzma_pkg::CFG_DATA_BITS-1:0] cfg_data;
	int in_idle;
	int out_idle;
	int sent;
	kz_smoother smoother = new();

	kzma_in_if sample_chan ();
	kzma_out_if result_chan ();

	kz_iterated_moving_average dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_chan(sample_chan),
		.result_chan(result_chan),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#10_000_000;
		$display("kz_iterated_moving_average regression: fail");
		$finish;
	end

	always @(negedge clk) begin
		result_chan.ready <= ($urandom_range(99) >= out_idle);
	end

	always @(posedge clk) begin
		if (arst_n && result_chan.valid && result_chan.ready)
			smoother.check_smoothed(result_chan.smoothed, result_chan.last_out);
	end

	// All tasks are entered at a falling edge and return at a falling edge.
	task automatic send_sample(logic [kzma_pkg::PORT_BITS-1:0] x, logic last);
		while ($urandom_range(99) < in_idle) begin
			sample_chan.valid <= 1'b0;
			@(negedge clk);
		end
		sample_chan.valid <= 1'b1;
		sample_chan.sample <= x;
		sample_chan.last_in <= last;
		@(posedge clk);
		while (!sample_chan.ready) @(posedge clk);
		smoother.take_sample(x, last);
		sent++;
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		sample_chan.valid <= 1'b0;
		@(negedge clk);
		while (smoother.awaited.size() != 0) @(negedge clk);
	endtask

	task automatic settle();
		hold_until_drained();
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [kzma_pkg::CFG_INDEX_BITS-1:0] index,
			logic [kzma_pkg::CFG_DATA_BITS-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		smoother.write_reg(index, data);
		@(negedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(int unsigned h, int unsigned it);
		write_reg(kzma_pkg::CFG_HALF_WIDTH,
			{1'($urandom_range(1)), kzma_pkg::HALF_BITS'(h)});
		write_reg(kzma_pkg::CFG_ITERATIONS, kzma_pkg::CFG_DATA_BITS'(it));
	endtask

	function automatic logic [kzma_pkg::PORT_BITS-1:0] pick_sample();
		case ($urandom_range(7))
			0: return '0;
			1: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic random_run(int budget);
		int start;
		int nseq;
		int len;
		int h;
		int it;
		bit broken;
		start = sent;
		while (sent - start < budget) begin
			case ($urandom_range(9))
				0: h = 0;
				1: h = 7;
				default: h = $urandom_range(1, 4);
			endcase
			case ($urandom_range(9))
				0: it = 0;
				1: it = $urandom_range(8, 15);
				default: it = $urandom_range(1, 5);
			endcase
			configure(h, it);
			nseq = $urandom_range(1, 3);
			for (int q = 0; q < nseq; q++) begin
				len = ($urandom_range(3) == 0) ? $urandom_range(1, 3) : $urandom_range(4, 14);
				broken = (q == nseq - 1) && ($urandom_range(5) == 0);
				for (int j = 0; j < len; j++) begin
					if ($urandom_range(39) == 0 || sent - start == 10)
						hold_until_drained();
					send_sample(pick_sample(), (j == len - 1) && !broken);
				end
			end
			settle();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_chan.valid = 1'b0;
		sample_chan.sample = '0;
		sample_chan.last_in = 1'b0;
		in_idle = 32;
		out_idle = 78;
		sent = 0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		send_sample(32'hFFFF_FFFF, 1'b0);
		send_sample(32'h0000_0000, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b0);
		send_sample(32'h0000_0001, 1'b0);
		send_sample(32'h8000_0000, 1'b1);
		settle();

		write_reg(kzma_pkg::CFG_HALF_WIDTH, 4'b1000);
		write_reg(kzma_pkg::CFG_ITERATIONS, 4'd5);
		send_sample(32'hFFFF_FFFF, 1'b0);
		send_sample(32'h0000_0000, 1'b1);
		settle();

		configure(3, 0);
		send_sample(32'h1234_5678, 1'b1);
		send_sample(32'hFFFF_FFFF, 1'b0);
		settle();

		configure(7, 15);
		send_sample(32'hFFFF_FFFF, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b0);
		send_sample(32'hFFFF_FFFF, 1'b1);
		send_sample(32'h0000_0100, 1'b1);
		settle();

		configure(2, 8);
		send_sample(32'hFFFF_FFFF, 1'b0);
		send_sample(32'h0000_0007, 1'b1);
		send_sample(32'hFFFF_FFFF, 1'b1);
		settle();

		// A register write in the middle of a sequence drops what the cells hold.
		configure(1, 1);
		send_sample(32'h0000_0010, 1'b0);
		send_sample(32'h0000_0020, 1'b0);
		send_sample(32'h0000_0030, 1'b0);
		settle();
		write_reg(kzma_pkg::CFG_ITERATIONS, 4'd2);
		send_sample(32'h0000_0040, 1'b0);
		send_sample(32'h0000_0050, 1'b1);
		settle();

		random_run(RANDOM_BUDGET);
		in_idle = 78;
		out_idle = 32;
		random_run(RANDOM_BUDGET);
		in_idle = 0;
		out_idle = 0;
		random_run(RANDOM_BUDGET);

		settle();
		if (smoother.mismatches == 0 && smoother.awaited.size() == 0) begin
			$display("kz_iterated_moving_average regression: pass");
		end else begin
			$display("kz_iterated_moving_average regression: fail");
		end
		$finish;
	end

endmodule

// ----- files.f -----
hdl/kzma_pkg.sv
hdl/kzma_if.sv
hdl/kzma_cell.sv
hdl/kzma_iterated_moving_average.sv
tb/sv/testbench.sv
